FILE: hw/rtl/esp_pkg.sv
// Shared types and constants for the expiring slot pool.
`default_nettype none
package esp_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int LIFE_W    = 20;
  localparam int ELAP_W    = 16;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_AW    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  localparam logic [CFG_AW-1:0] REG_LIFETIME   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_START_FREE = 3'd4;

  // Per-cell command, broadcast to every cell of the row.
  typedef struct packed {
    logic             restart;
    logic             all_free;
    logic             alloc;
    logic             tick;
    logic [LIFE_W-1:0] life;
  } cell_cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/esp_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none
interface esp_in_if import esp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ELAP_W-1:0] elapsed_ms;
  modport source (output valid, kind, elapsed_ms, input ready);
  modport sink   (input valid, kind, elapsed_ms, output ready);
endinterface

interface esp_out_if import esp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot_index;
  logic             granted;
  logic [CNT_W-1:0] expired_count;
  logic [CNT_W-1:0] free_count;
  modport source (output valid, slot_index, granted, expired_count, free_count, input ready);
  modport sink   (input valid, slot_index, granted, expired_count, free_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/esp_cell.sv
// One slot cell: liveness, remaining time, and its place in the shifting row.
`default_nettype none
module esp_cell import esp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_cmd_t         cmd,
  input  wire logic              sel,       // alloc target
  input  wire logic              shift,     // tick walk: take neighbour's state
  input  wire logic [ELAP_W-1:0] elapsed,
  input  wire logic              in_live,
  input  wire logic [LIFE_W-1:0] in_rem,
  output      logic              live_r,
  output      logic [LIFE_W-1:0] rem_r,
  output      logic              exp_now     // head cell: expires on this step
);
  logic [LIFE_W-1:0] dec;
  assign dec     = (rem_r > LIFE_W'(elapsed)) ? rem_r - LIFE_W'(elapsed) : '0;
  assign exp_now = live_r && (dec == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      rem_r  <= '0;
    end else if (cmd.restart) begin
      live_r <= !cmd.all_free;
      rem_r  <= cmd.all_free ? '0 : cmd.life;
    end else if (cmd.alloc && sel) begin
      live_r <= 1'b1;
      rem_r  <= cmd.life;
    end else if (shift) begin
      live_r <= in_live;
      rem_r  <= in_rem;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/esp_stack.sv
// Free slot stack held in a memory with a registered read, with push and pop.
`default_nettype none
module esp_stack import esp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     restart,
  input  wire logic                     all_free,
  input  wire logic                     push,
  input  wire logic [$clog2(SLOTS+1)-1:0] push_val,
  input  wire logic                     pop,
  output      logic [$clog2(SLOTS+1)-1:0] depth_r,
  output      logic [$clog2(SLOTS+1)-1:0] top
);
  localparam int DW = $clog2(SLOTS+1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  logic [DW-1:0] stk_r [SLOTS];
  logic [DW-1:0] rd_r;        // top entry, read ahead at the next depth so it lines up with depth_r
  logic [DW-1:0] lo_r;        // entries below this mark still hold their own index
  logic [DW-1:0] depth_nxt;
  logic [AW-1:0] top_a;
  logic [AW-1:0] rd_a;
  logic          wr_en;
  logic          pop_en;

  assign wr_en  = rst_n && !restart && push && (depth_r < DW'(SLOTS));
  assign pop_en = rst_n && !restart && !wr_en && pop && (depth_r != '0);

  always_comb begin
    if (!rst_n || restart) begin
      depth_nxt = (!rst_n || all_free) ? DW'(SLOTS) : '0;
    end else if (wr_en) begin
      depth_nxt = depth_r + DW'(1);
    end else if (pop_en) begin
      depth_nxt = depth_r - DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  assign rd_a  = AW'(depth_nxt - DW'(1));
  assign top_a = AW'(depth_r - DW'(1));
  assign top   = (DW'(top_a) < lo_r) ? DW'(top_a) : rd_r;

  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
    if (!rst_n || restart) begin
      lo_r <= (!rst_n || all_free) ? DW'(SLOTS) : '0;
    end else if (wr_en && depth_r < lo_r) begin
      lo_r <= depth_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) stk_r[AW'(depth_r)] <= push_val;
  end

  // a push lands exactly where the next top is, so forward it
  always_ff @(posedge clk) begin
    if (wr_en) rd_r <= push_val;
    else       rd_r <= stk_r[rd_a];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    push && !restart |-> depth_r < DW'(SLOTS)) else $error("push on full stack");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> depth_r != '0) else $error("pop on empty stack");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && pop)) else $error("push and pop together");
  assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= DW'(SLOTS)) else $error("fill mark out of range");
endmodule
`default_nettype wire

FILE: hw/rtl/expiring_slot_pool_top.sv
// Top level of the expiring slot pool: cell row, free stack, control and APB.
// Usage: transactions on in_ (kind, elapsed_ms) each give one transaction on out_.
// Allocate and restart act in state DONE and then load the result register. A tick
// with a nonzero lifetime rotates the row of SLOTS cells once past the head cell
// in state WALK, one slot per cycle; the rotation sets the rate. A tick with zero
// lifetime or kind 3 goes through state DONE alone. One item at a time.
// The result sits in an output register until out_ready; a new item is
// accepted while it waits if the register is free when the work ends,
// otherwise the block holds the result and stalls.
// Reset (rst_n low, synchronous) sets lifetime 0, start_free 1, all slots free,
// stack entry i = i. No clearing pass. cfg_ is APB, pready always high:
// register 0 lifetime_ms at 0x0, register 1 start_free at 0x4.
`default_nettype none
module expiring_slot_pool_top import esp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  esp_in_if.sink                 in_ch,
  esp_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output      logic [31:0]       cfg_prdata,
  output      logic              cfg_pready
);
  localparam int DW = $clog2(SLOTS+1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r;
  logic [LIFE_W-1:0] life_r;
  logic              start_free_r;
  kind_t             kind_r;
  logic [ELAP_W-1:0] elap_r;
  logic [DW-1:0]     cnt_r;      // slots walked; head holds slot cnt_r
  logic [CNT_W-1:0]  exp_r;
  logic [IDX_W-1:0]  idx_r;
  logic              gnt_r;
  logic              ov_r;
  logic [IDX_W-1:0]  o_idx_r;
  logic              o_gnt_r;
  logic [CNT_W-1:0]  o_exp_r, o_free_r;

  cell_cmd_t         cmd;
  logic              live [SLOTS];
  logic [LIFE_W-1:0] rem  [SLOTS];
  logic              expn [SLOTS];
  logic              shift;
  logic [DW-1:0]     depth, top;
  logic              acc, pop, push;
  logic [AW-1:0]     sel_a;
  logic              cap;

  // APB
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r       <= '0;
      start_free_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        REG_LIFETIME:   life_r       <= cfg_pwdata[LIFE_W-1:0];
        REG_START_FREE: start_free_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      REG_LIFETIME:   cfg_prdata = 32'(life_r);
      REG_START_FREE: cfg_prdata = 32'(start_free_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;

  // Commands act in the cycle after acceptance (state DONE-entry via registers).
  logic go_r;
  assign cmd.restart  = go_r && kind_r == KIND_RESTART;
  assign cmd.all_free = start_free_r;
  assign cmd.alloc    = pop;
  assign cmd.tick     = shift;
  assign cmd.life     = life_r;
  assign pop   = go_r && kind_r == KIND_ALLOC && depth != '0;
  assign sel_a = AW'(top);
  assign shift = (state_r == ST_WALK);
  assign push  = shift && expn[0];
  // result register loads once the work is done and the register is free
  assign cap   = (state_r == ST_DONE) && !go_r && (!ov_r || out_ch.ready);

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    localparam int NX = (g + 1) % SLOTS;
    logic nl;
    logic [LIFE_W-1:0] nr;
    // head cell writes back its decremented state into the tail
    if (g == SLOTS - 1) begin : g_tail
      assign nl = live[0] && !expn[0];
      assign nr = (rem[0] > LIFE_W'(elap_r)) ? rem[0] - LIFE_W'(elap_r) : '0;
    end else begin : g_mid
      assign nl = live[NX];
      assign nr = rem[NX];
    end
    esp_cell u_cell (
      .clk, .rst_n, .cmd,
      .sel     (sel_a == AW'(g)),
      .shift,
      .elapsed (elap_r),
      .in_live (nl),
      .in_rem  (nr),
      .live_r  (live[g]),
      .rem_r   (rem[g]),
      .exp_now (expn[g])
    );
  end

  esp_stack #(.SLOTS(SLOTS)) u_stack (
    .clk, .rst_n,
    .restart  (cmd.restart),
    .all_free (start_free_r),
    .push,
    .push_val (cnt_r),
    .pop,
    .depth_r  (depth),
    .top
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      go_r <= acc;
      if (cap) ov_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (acc) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (go_r) begin
            if (kind_r == KIND_TICK && life_r != '0) begin
              state_r <= ST_WALK;
              cnt_r   <= '0;
            end
          end else if (cap) begin
            state_r <= ST_IDLE;
          end
        end
        ST_WALK: begin
          cnt_r <= cnt_r + DW'(1);
          if (cnt_r == DW'(SLOTS - 1)) state_r <= ST_DONE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r <= kind_t'(in_ch.kind);
      elap_r <= in_ch.elapsed_ms;
      exp_r  <= '0;
      idx_r  <= '0;
      gnt_r  <= 1'b0;
    end else begin
      if (push) exp_r <= exp_r + CNT_W'(1);
      if (pop) begin
        idx_r <= IDX_W'(top);
        gnt_r <= 1'b1;
      end
    end
    if (cap) begin
      o_idx_r  <= idx_r;
      o_gnt_r  <= gnt_r;
      o_exp_r  <= exp_r;
      o_free_r <= CNT_W'(depth);
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.slot_index    = o_idx_r;
  assign out_ch.granted       = o_gnt_r;
  assign out_ch.expired_count = o_exp_r;
  assign out_ch.free_count    = o_free_r;

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> state_r == ST_DONE);
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !pop) else $error("push/pop clash");
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready) else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> kind_r == KIND_TICK && life_r != '0) else $error("walk without tick");
endmodule
`default_nettype wire

FILE: dv/esp_checker.sv
// Checker for the expiring slot pool: watches both channels, predicts and compares results.
`timescale 1ns / 100ps
`default_nettype none
module esp_checker import esp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [ELAP_W-1:0] in_elapsed,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [IDX_W-1:0] out_slot,
  input  wire logic        out_granted,
  input  wire logic [CNT_W-1:0] out_expired,
  input  wire logic [CNT_W-1:0] out_free,
  input  wire logic        cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               grants_seen,
  output int               expiries_seen
);
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             granted;
    logic [CNT_W-1:0] expired;
    logic [CNT_W-1:0] free;
  } pool_result_t;

  localparam int N = SLOTS_DEF;

  logic [LIFE_W-1:0] life_cfg;
  logic              free_cfg;
  logic [LIFE_W-1:0] remain [N];
  logic              live   [N];
  logic [IDX_W-1:0]  stack  [N];
  int                depth;
  pool_result_t      results_due [$];

  function automatic void rebuild_pool();
    for (int i = 0; i < N; i++) begin
      stack[i]  = IDX_W'(i);
      live[i]   = !free_cfg;
      remain[i] = free_cfg ? '0 : life_cfg;
    end
    depth = free_cfg ? N : 0;
  endfunction

  function automatic pool_result_t predict_item(kind_t k, logic [ELAP_W-1:0] el);
    pool_result_t r;
    int s;
    r = '0;
    case (k)
      KIND_TICK: begin
        if (life_cfg != 0) begin
          for (int i = 0; i < N; i++) begin
            if (live[i]) begin
              remain[i] = (remain[i] > el) ? remain[i] - el : '0;
              if (remain[i] == 0) begin
                live[i] = 1'b0;
                r.expired++;
                if (depth < N) begin
                  stack[depth] = IDX_W'(i);
                  depth++;
                end
              end
            end
          end
        end
      end
      KIND_ALLOC: begin
        if (depth > 0) begin
          depth--;
          s = stack[depth];
          live[s] = 1'b1;
          remain[s] = life_cfg;
          r.slot = IDX_W'(s);
          r.granted = 1'b1;
        end
      end
      KIND_RESTART: rebuild_pool();
      default: ;
    endcase
    r.free = CNT_W'(depth);
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    pool_result_t exp_r;
    if (!rst_n) begin
      life_cfg = '0;
      free_cfg = 1'b1;
      rebuild_pool();
      results_due.delete();
      fail_count <= 0;
      grants_seen <= 0;
      expiries_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_LIFETIME) life_cfg = cfg_data[LIFE_W-1:0];
        else if (cfg_addr == REG_START_FREE) free_cfg = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (out_granted) grants_seen <= grants_seen + 1;
          if (out_expired != 0) expiries_seen <= expiries_seen + 1;
          if (out_slot !== exp_r.slot || out_granted !== exp_r.granted ||
              out_expired !== exp_r.expired || out_free !== exp_r.free) begin
            if (out_slot !== exp_r.slot)
              $error("slot_index expected %0d got %0d", exp_r.slot, out_slot);
            if (out_granted !== exp_r.granted)
              $error("granted expected %0d got %0d", exp_r.granted, out_granted);
            if (out_expired !== exp_r.expired)
              $error("expired_count expected %0d got %0d", exp_r.expired, out_expired);
            if (out_free !== exp_r.free)
              $error("free_count expected %0d got %0d", exp_r.free, out_free);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(predict_item(kind_t'(in_kind), in_elapsed));
    end
  end
endmodule
`default_nettype wire

FILE: dv/tb_expiring_slot_pool_top.sv
// Testbench top for the expiring slot pool: stimulus, APB writes and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_expiring_slot_pool_top;
  import esp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fails, pending, grants, expiries;
  int cycles = 0;
  int sent = 0;

  esp_in_if  in_ch ();
  esp_out_if out_ch ();

  expiring_slot_pool_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  esp_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
    .in_elapsed(in_ch.elapsed_ms),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_slot(out_ch.slot_index),
    .out_granted(out_ch.granted), .out_expired(out_ch.expired_count),
    .out_free(out_ch.free_count),
    .cfg_we(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_addr(cfg_paddr), .cfg_data(cfg_pwdata),
    .fail_count(fails), .pending(pending), .grants_seen(grants),
    .expiries_seen(expiries)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("expiring_slot_pool_top verification failed");
      $finish;
    end
  end

  // receiver: random stall before each result transaction
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  // valid stays high after a transaction until the next item or an idle phase
  task automatic send_item(kind_t k, logic [ELAP_W-1:0] el, bit bursty);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.elapsed_ms <= el;
    @(posedge clk iff in_ch.ready);
    sent++;
  endtask

  task automatic drain_pool();
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ELAP_W-1:0] rand_elapsed();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return ELAP_W'($urandom);
      default: return ELAP_W'($urandom_range(0, 40));
    endcase
  endfunction

  initial begin
    logic [LIFE_W-1:0] life_pick;
    kind_t k;
    int r;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.elapsed_ms <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero-lifetime tick, empty stack, full stack, saturation, kind 3
    send_item(KIND_TICK, '1, 0);
    send_item(KIND_ALLOC, '0, 0);
    send_item(KIND_ALLOC, '1, 0);
    send_item(KIND_TICK, '0, 0);
    send_item(KIND_NONE, '1, 0);
    drain_pool();
    reg_write(REG_START_FREE, 32'd0);
    send_item(KIND_RESTART, '0, 0);
    send_item(KIND_ALLOC, '0, 0);
    drain_pool();
    reg_write(REG_LIFETIME, 32'd5);
    send_item(KIND_TICK, '0, 0);
    drain_pool();
    reg_write(REG_LIFETIME, 32'hFFFFF);
    send_item(KIND_RESTART, '0, 0);
    send_item(KIND_TICK, '1, 0);
    send_item(KIND_TICK, 16'd1, 0);
    for (int i = 0; i < 16; i++) send_item(KIND_TICK, '1, 1);
    send_item(KIND_ALLOC, '0, 0);
    send_item(KIND_NONE, '0, 0);
    drain_pool();
    reg_write(REG_START_FREE, 32'd1);
    send_item(KIND_RESTART, '0, 0);

    // random phases, several settings
    for (int ph = 0; ph < 12; ph++) begin
      drain_pool();
      case (ph % 4)
        0: life_pick = LIFE_W'($urandom_range(1, 60));
        1: life_pick = '0;
        2: life_pick = '1;
        default: life_pick = LIFE_W'($urandom);
      endcase
      reg_write(REG_LIFETIME, {12'd0, life_pick});
      reg_write(REG_START_FREE, {31'd0, 1'($urandom_range(0, 1))});
      for (int n = 0; n < 158; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) k = KIND_ALLOC;
        else if (r < 90) k = KIND_TICK;
        else if (r < 97) k = KIND_RESTART;
        else k = KIND_NONE;
        send_item(k, rand_elapsed(), (n % 40) < 8);
        if (n == 80 && ph == 5) begin
          in_ch.valid <= 1'b0;
          @(posedge clk iff pending == 0);
        end
      end
    end

    drain_pool();
    $display("Run sent %0d items over twelve register settings; %0d grants, %0d ticks with expiries.",
             sent, grants, expiries);
    if (fails == 0) begin
      $display("expiring_slot_pool_top verification clean");
    end else begin
      $display("expiring_slot_pool_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
